// File: sv/bqc_pkg.sv
// Shared widths, register indexes and the 2x2 window test for the bit-quad corner counter.
package bqc_pkg;

	localparam int CFG_W   = 11;
	localparam int COUNT_W = 21;
	localparam int ADD_W   = 3;

	localparam logic [COUNT_W-1:0] COUNT_LIMIT = {COUNT_W{1'b1}};

	localparam logic REG_IMAGE_ROWS = 1'b0;
	localparam logic REG_IMAGE_COLS = 1'b1;

	// Window a b / d e: a corner unless uniform or made of two equal halves.
	function automatic logic is_corner(input logic a, input logic b, input logic d,
		input logic e);
		logic rows_equal;
		logic cols_equal;
		rows_equal = (a == b) && (d == e);
		cols_equal = (a == d) && (b == e);
		return !rows_equal && !cols_equal;
	endfunction

endpackage

// File: sv/binary_image_corner_quad_counter_unit.sv
// Top level: streaming 2x2 bit-quad corner counter over a zero-padded binary frame.
// Throughput: one pixel beat per cycle; a final pixel stalls only behind an untaken count.
// Output path: the final pixel beat is registered into stage 1 together with the line-buffer
// read, then its total is loaded into the output register; stage 1 holds while that is full.
// Reset: arst_n clears position, running count, pipeline and output valid; frame size returns to 1x1.
// The line buffer is not cleared; its bit is only used on rows after the first of a frame.
module binary_image_corner_quad_counter_unit
	import bqc_pkg::*;
#(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               pixel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COUNT_W-1:0] corner_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	// Column/row index widths and the widths that hold the frame size itself.
	localparam int CI    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RI    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int CCMPW = (CW > CFG_W) ? CW : CFG_W;
	localparam int RCMPW = (RW > CFG_W) ? RW : CFG_W;

	// Effective frame size, clamped to 1..MAX at write time.
	logic [CW-1:0] cols_eff_q;
	logic [RW-1:0] rows_eff_q;

	// Position of the next pixel in the frame.
	logic [CI-1:0] col_q;
	logic [RI-1:0] row_q;

	// Line buffer: one bit per column, holding the previous row.
	logic          line_mem [MAX_COLS];
	logic          above_s1;

	// Stage 1: the accepted pixel and where it sits in the frame.
	logic          s1_valid_q;
	logic          pix_s1;
	logic          first_row_s1;
	logic          first_col_s1;
	logic          last_col_s1;
	logic          last_row_s1;

	// Window history, updated as stage 1 retires.
	logic          left_q;
	logic          above_left_q;
	logic [COUNT_W-1:0] running_q;

	// Output register.
	logic               out_valid_q;
	logic [COUNT_W-1:0] count_q;

	logic               accept;
	logic               cfg_write;
	logic               last_col;
	logic               last_row;
	logic               advance;
	logic               frame_done;
	logic               up;
	logic               ul;
	logic               lf;
	logic [ADD_W-1:0]   add;
	logic [COUNT_W:0]   sum_wide;
	logic [COUNT_W-1:0] sum;
	logic [CCMPW-1:0]   cols_req;
	logic [RCMPW-1:0]   rows_req;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	// Hold stage 1 only when it carries the final pixel and the output is still full.
	assign frame_done = s1_valid_q && last_col_s1 && last_row_s1;
	assign advance    = s1_valid_q && (!frame_done || !out_valid_q || out_ready);
	assign in_ready   = !s1_valid_q || advance;
	assign accept     = in_valid && in_ready;

	assign last_col = ((CW'(col_q) + CW'(1)) == cols_eff_q);
	assign last_row = ((RW'(row_q) + RW'(1)) == rows_eff_q);

	// Clamp a size write: zero acts as one, anything above the limit acts as the limit.
	assign cols_req = CCMPW'(cfg_data);
	assign rows_req = RCMPW'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_eff_q <= CW'(1);
			rows_eff_q <= RW'(1);
		end else if (cfg_write) begin
			if (cfg_index == REG_IMAGE_COLS) begin
				if (cols_req == '0) begin
					cols_eff_q <= CW'(1);
				end else if (cols_req > CCMPW'(MAX_COLS)) begin
					cols_eff_q <= CW'(MAX_COLS);
				end else begin
					cols_eff_q <= CW'(cols_req);
				end
			end else begin
				if (rows_req == '0) begin
					rows_eff_q <= RW'(1);
				end else if (rows_req > RCMPW'(MAX_ROWS)) begin
					rows_eff_q <= RW'(MAX_ROWS);
				end else begin
					rows_eff_q <= RW'(rows_req);
				end
			end
		end
	end

	// Advance the raster position on each accepted beat; a size write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_write) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (!last_col) begin
				col_q <= col_q + CI'(1);
			end else begin
				col_q <= '0;
				if (!last_row) begin
					row_q <= row_q + RI'(1);
				end else begin
					row_q <= '0;
				end
			end
		end
	end

	// Read the previous row's bit and overwrite it with the new pixel in the same cycle.
	// Read-before-write on one address gives the old bit, so a one-column frame needs
	// no forwarding: the next row's read comes with a later beat, after this write.
	always_ff @(posedge clk) begin
		if (accept) begin
			above_s1       <= line_mem[col_q];
			line_mem[col_q] <= pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= pixel;
			first_row_s1 <= (row_q == '0);
			first_col_s1 <= (col_q == '0);
			last_col_s1  <= last_col;
			last_row_s1  <= last_row;
		end
	end

	// Build the window: padding zeros on the first row and first column.
	assign up = first_row_s1 ? 1'b0 : above_s1;
	assign ul = (first_row_s1 || first_col_s1) ? 1'b0 : above_left_q;
	assign lf = first_col_s1 ? 1'b0 : left_q;

	// Score the interior window plus the padded windows to the right, below and diagonal.
	always_comb begin
		add = ADD_W'(is_corner(ul, up, lf, pix_s1));
		if (last_col_s1) begin
			add = add + ADD_W'(is_corner(up, 1'b0, pix_s1, 1'b0));
		end
		if (last_row_s1) begin
			add = add + ADD_W'(is_corner(lf, pix_s1, 1'b0, 1'b0));
			if (last_col_s1) begin
				add = add + ADD_W'(is_corner(pix_s1, 1'b0, 1'b0, 1'b0));
			end
		end
	end

	// Saturate the running total.
	assign sum_wide = {1'b0, running_q} + (COUNT_W + 1)'(add);
	assign sum      = sum_wide[COUNT_W] ? COUNT_LIMIT : sum_wide[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= '0;
			left_q       <= 1'b0;
			above_left_q <= 1'b0;
		end else if (cfg_write) begin
			running_q    <= '0;
			left_q       <= 1'b0;
			above_left_q <= 1'b0;
		end else if (advance) begin
			running_q    <= frame_done ? '0 : sum;
			left_q       <= pix_s1;
			above_left_q <= up;
		end
	end

	// Output register: load the total on the final pixel, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && frame_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_done) begin
			count_q <= sum;
		end
	end

	assign out_valid    = out_valid_q;
	assign corner_count = count_q;

endmodule

// File: sim/binary_image_corner_quad_counter_unit_tb.sv
// Self-checking bench for the bit-quad corner counter: table-driven frames, then random frames.
module binary_image_corner_quad_counter_unit_tb
	import bqc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_COLS   = 1024;
	localparam int MAX_ROWS   = 1024;
	// Depth of the output path (stage 1, then the output register); drain pads beyond it.
	localparam int LAT        = 2;
	localparam int LONG_HOLD  = 150;
	localparam int RAND_ITEMS = 530;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               pixel = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COUNT_W-1:0] corner_count;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_index = REG_IMAGE_ROWS;
	logic [CFG_W-1:0]   cfg_data = '0;

	binary_image_corner_quad_counter_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.corner_count(corner_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Counts the block still owes us, oldest first.
	logic [COUNT_W-1:0] pending_counts [$];

	int errors      = 0;
	int pix_beats   = 0;
	int cfg_beats   = 0;
	int counts_seen = 0;

	// Knobs shared between the stimulus thread and the receiver.
	bit calm     = 1'b0;   // no idling on either side
	bit tx_quiet = 1'b0;   // sender runs gap-free for the current frame
	bit hold_go  = 1'b0;   // request one long receiver hold-off

	// ------------------------------------------------------------------
	// Corner-count predictor: shadow of the frame size, line buffer and
	// window position, advanced once per accepted pixel beat.
	// ------------------------------------------------------------------
	logic [CFG_W-1:0]   size_rows = 11'd1;
	logic [CFG_W-1:0]   size_cols = 11'd1;
	logic               line_buf [0:MAX_COLS-1];
	logic               left_bit = 1'b0;
	logic               diag_bit = 1'b0;
	int                 cur_row = 0;
	int                 cur_col = 0;
	int                 run_total = 0;

	function automatic int clamp_size(input logic [CFG_W-1:0] v, input int lim);
		if (v == '0)
			return 1;
		if (int'(v) > lim)
			return lim;
		return int'(v);
	endfunction

	// A 2x2 window is a corner when it holds an odd number of ones, or when it is
	// a diagonal pair (the only even pattern that is not split into equal halves).
	function automatic int quad_is_corner(input logic a, input logic b, input logic d,
		input logic e);
		int ones;
		ones = int'(a) + int'(b) + int'(d) + int'(e);
		return ((ones % 2) == 1 || (a == e && b == d && a != b)) ? 1 : 0;
	endfunction

	function automatic void restart_frame();
		left_bit  = 1'b0;
		diag_bit  = 1'b0;
		cur_row   = 0;
		cur_col   = 0;
		run_total = 0;
	endfunction

	// Any size write drops the frame in progress.
	function automatic void load_size_reg(input logic idx, input logic [CFG_W-1:0] val);
		if (idx == REG_IMAGE_ROWS)
			size_rows = val;
		else
			size_cols = val;
		restart_frame();
	endfunction

	// Advance one pixel; return 1 with the frame total when it closes the frame.
	function automatic bit count_pixel(input logic p, output logic [COUNT_W-1:0] total);
		int  rows;
		int  cols;
		int  r;
		int  c;
		int  add;
		int  sum;
		logic up;
		logic ul;
		logic lf;
		bit  end_col;
		bit  end_row;
		rows = clamp_size(size_rows, MAX_ROWS);
		cols = clamp_size(size_cols, MAX_COLS);
		r = (cur_row >= rows) ? 0 : cur_row;
		c = (cur_col >= cols) ? 0 : cur_col;
		end_col = (c + 1 == cols);
		end_row = (r + 1 == rows);
		// First row and first column see the zero ring, not the buffers.
		up = (r == 0) ? 1'b0 : line_buf[c];
		ul = (r == 0 || c == 0) ? 1'b0 : diag_bit;
		lf = (c == 0) ? 1'b0 : left_bit;
		add = quad_is_corner(ul, up, lf, p);
		// Windows reaching into the right and bottom padding.
		if (end_col)
			add += quad_is_corner(up, 1'b0, p, 1'b0);
		if (end_row) begin
			add += quad_is_corner(lf, p, 1'b0, 1'b0);
			if (end_col)
				add += quad_is_corner(p, 1'b0, 1'b0, 1'b0);
		end
		diag_bit   = up;
		line_buf[c] = p;
		left_bit   = p;
		sum = run_total + add;
		if (sum > int'(COUNT_LIMIT))
			sum = int'(COUNT_LIMIT);
		total = sum[COUNT_W-1:0];
		if (!end_col) begin
			cur_col   = c + 1;
			cur_row   = r;
			run_total = sum;
			return 1'b0;
		end
		cur_col = 0;
		if (!end_row) begin
			cur_row   = r + 1;
			run_total = sum;
			return 1'b0;
		end
		restart_frame();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Beat drivers. All drives are nonblocking at the rising edge; the
	// handshake is read right after the edge, i.e. the pre-edge values.
	// ------------------------------------------------------------------
	task automatic send_pixel(input logic p, input logic typed,
		input logic [COUNT_W-1:0] typed_count);
		logic [COUNT_W-1:0] total;
		// Drop valid for a random burst now and then.
		if (!calm && !tx_quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pix_beats++;
		// Rows with a hand-written count use it; the predictor still advances.
		if (count_pixel(p, total))
			pending_counts.push_back(typed ? typed_count : total);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_beats++;
		load_size_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Hold the sender until every owed count is back, then let the pipe settle
	// (a partial frame may still be in flight with nothing owed).
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_counts.size() != 0) @(posedge clk);
		repeat (LAT + 2) @(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_size(input int hi);
		if ($urandom_range(0, 9) == 0)
			return '0;
		return CFG_W'($urandom_range(1, hi));
	endfunction

	// ------------------------------------------------------------------
	// Directed script: size edge cases, 1x1 after reset, halves, diagonal,
	// full square and a frame abandoned by a size write.
	// ------------------------------------------------------------------
	typedef enum logic {DO_WRITE, DO_PIXEL} step_kind_e;

	typedef struct packed {
		step_kind_e         kind;
		logic               reg_idx;
		logic [CFG_W-1:0]   value;
		logic               pix;
		logic               typed;
		logic [COUNT_W-1:0] count;
	} step_t;

	localparam int N_STEPS = 31;

	step_t script [0:N_STEPS-1] = '{
		// 1x1 frame straight out of reset: empty, then a lone one
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b0, 1'b1, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b1, 21'd4},
		// zero sizes behave as one
		'{DO_WRITE, REG_IMAGE_ROWS, 11'd0, 1'b0, 1'b0, 21'd0},
		'{DO_WRITE, REG_IMAGE_COLS, 11'd0, 1'b0, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b1, 21'd4},
		// 1x2: a bar, then a single one
		'{DO_WRITE, REG_IMAGE_ROWS, 11'd1, 1'b0, 1'b0, 21'd0},
		'{DO_WRITE, REG_IMAGE_COLS, 11'd2, 1'b0, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b1, 21'd4},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b0, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b1, 21'd4},
		// 2x2: diagonal pair, then a solid square
		'{DO_WRITE, REG_IMAGE_ROWS, 11'd2, 1'b0, 1'b0, 21'd0},
		'{DO_WRITE, REG_IMAGE_COLS, 11'd2, 1'b0, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b0, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b0, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b1, 21'd4},
		// half a 2x2 frame, then a size write throws it away
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b0, 1'b0, 21'd0},
		'{DO_WRITE, REG_IMAGE_COLS, 11'd3, 1'b0, 1'b0, 21'd0},
		'{DO_WRITE, REG_IMAGE_ROWS, 11'd1, 1'b0, 1'b0, 21'd0},
		// 1x3: blank, then two separated ones
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b0, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b0, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b0, 1'b1, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b0, 1'b0, 21'd0},
		'{DO_PIXEL, REG_IMAGE_ROWS, 11'd0, 1'b1, 1'b0, 21'd0}
	};

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, quiet stretches, and one long hold-off
	// on request so results back up and the block stalls its input.
	// ------------------------------------------------------------------
	int hold_left     = 0;
	int stall_left    = 0;
	int rx_quiet_left = 0;

	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else begin
			if (rx_quiet_left > 0)
				rx_quiet_left <= rx_quiet_left - 1;
			else if ($urandom_range(0, 99) == 0)
				rx_quiet_left <= $urandom_range(20, 80);
			if (!calm && rx_quiet_left == 0 && $urandom_range(0, 7) == 0) begin
				out_ready  <= 1'b0;
				stall_left <= $urandom_range(0, 9);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every accepted count beat must match the oldest owed one.
	// ------------------------------------------------------------------
	logic [COUNT_W-1:0] want_count;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_counts.size() == 0) begin
				$display("%0t ns: unexpected count beat, expected none, got %0d",
					$time, corner_count);
				errors++;
			end else begin
				want_count = pending_counts.pop_front();
				counts_seen++;
				if (corner_count !== want_count) begin
					$display("%0t ns: corner_count mismatch, expected %0d, got %0d",
						$time, want_count, corner_count);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int frame_len;
		int dens;
		int n;
		int pick;
		int rand_beats;
		bit cut;
		bit need_cfg;

		foreach (line_buf[i])
			line_buf[i] = 1'b0;
		rand_beats = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed script; size writes only once the block is idle.
		foreach (script[i]) begin
			if (script[i].kind == DO_WRITE) begin
				drain();
				write_reg(script[i].reg_idx, script[i].value);
			end else begin
				send_pixel(script[i].pix, script[i].typed, script[i].count);
			end
		end

		// Back-pressure: 1x1 frames give a count per pixel; hold the receiver off
		// long enough that the output fills and in_ready drops, keep offering.
		drain();
		write_reg(REG_IMAGE_ROWS, 11'd1);
		write_reg(REG_IMAGE_COLS, 11'd1);
		tx_quiet = 1'b1;
		hold_go  = 1'b1;
		repeat (40)
			send_pixel(1'($urandom_range(0, 1)), 1'b0, '0);
		tx_quiet = 1'b0;
		// Pause the sender until every count is back.
		drain();

		// Random small frames: mostly complete, with random density, some
		// back-to-back at the same size, a few cut short by a size write.
		need_cfg = 1'b1;
		while (rand_beats < RAND_ITEMS) begin
			// Finish with a stretch free of idling on both sides.
			if (rand_beats >= RAND_ITEMS - 100)
				calm = 1'b1;
			if (need_cfg || (!calm && $urandom_range(0, 3) == 0)) begin
				drain();
				pick = $urandom_range(0, 3);
				if (pick != 0)
					write_reg(REG_IMAGE_ROWS, pick_size(5));
				if (pick != 1)
					write_reg(REG_IMAGE_COLS, pick_size(6));
				need_cfg = 1'b0;
			end
			frame_len = clamp_size(size_rows, MAX_ROWS) * clamp_size(size_cols, MAX_COLS);
			dens      = $urandom_range(0, 4);
			tx_quiet  = ($urandom_range(0, 4) == 0);
			cut       = !calm && (frame_len > 1) && ($urandom_range(0, 11) == 0);
			n         = cut ? $urandom_range(1, frame_len - 1) : frame_len;
			repeat (n) begin
				send_pixel($urandom_range(0, 3) < dens, 1'b0, '0);
				rand_beats++;
			end
			if (cut)
				need_cfg = 1'b1;
		end
		tx_quiet = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		$display("Run covered %0d pixel beats and %0d size writes; %0d frame counts checked.",
			pix_beats, cfg_beats, counts_seen);
		$display("Mismatches or stray counts: %0d.", errors);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#1000000;
		$display("Timeout with %0d counts still owed.", pending_counts.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
